// File: rtl/twp_pkg.sv
// ----------------------------------------------------------------------------
// twp_pkg
// Shared types and register indices for the triangular work partition.
// ----------------------------------------------------------------------------
package twp_pkg;

    localparam int unsigned CFG_IDX_BITS = 2;
    localparam int unsigned CFG_DATA_BITS = 16;
    localparam int unsigned OUT_BITS = 16;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_ITEM_COUNT   = 2'd0,
        REG_WORKER_COUNT = 2'd1,
        REG_SPLIT_MODE   = 2'd2
    } t_cfg_idx;

    // control flags travelling with each request
    typedef struct packed {
        logic vld;
        logic ok;
        logic nz;
        logic blk;
        logic first;
        logic last;
    } t_ctl;

endpackage

// File: rtl/twp_div_cell.sv
// ----------------------------------------------------------------------------
// twp_div_cell
// One restoring division step: shifts one dividend bit into the remainder
// and one quotient bit into the low end of the shift word.
// ----------------------------------------------------------------------------
module twp_div_cell #(
    parameter int unsigned CB = 16,
    parameter int unsigned DW = 32,
    parameter int unsigned SW = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  twp_pkg::t_ctl        i_ctl,
    input  logic [CB-1:0]        i_rem,
    input  logic [DW-1:0]        i_dq,
    input  logic [CB-1:0]        i_div,
    input  logic [SW-1:0]        i_side,
    output twp_pkg::t_ctl        o_ctl,
    output logic [CB-1:0]        o_rem,
    output logic [DW-1:0]        o_dq,
    output logic [CB-1:0]        o_div,
    output logic [SW-1:0]        o_side
);

    logic [CB:0]   n_trial;
    logic          n_ge;
    logic [CB:0]   n_diff;
    logic [CB-1:0] n_rem;
    logic [DW-1:0] n_dq;

    always_comb begin
        n_trial = {i_rem, i_dq[DW-1]};
        n_ge    = (n_trial >= {1'b0, i_div});
        n_diff  = n_trial - {1'b0, i_div};
        n_rem   = n_ge ? n_diff[CB-1:0] : n_trial[CB-1:0];
        n_dq    = {i_dq[DW-2:0], n_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ctl <= '0;
        end else begin
            o_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rem  <= n_rem;
        o_dq   <= n_dq;
        o_div  <= i_div;
        o_side <= i_side;
    end

endmodule

// File: rtl/twp_root_cell.sv
// ----------------------------------------------------------------------------
// twp_root_cell
// One bit step of the row root, largest k with k(k-1) <= limit, on two lanes.
// k(k-1) is kept incrementally so each trial is adds and fixed shifts only.
// ----------------------------------------------------------------------------
module twp_root_cell #(
    parameter int unsigned CB  = 16,
    parameter int unsigned BIT = 16,
    parameter int unsigned SW  = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  twp_pkg::t_ctl                 i_ctl,
    input  logic [1:0][CB:0]              i_k,
    input  logic [1:0][2*CB+1:0]          i_q,
    input  logic [1:0][2*CB-1:0]          i_lim,
    input  logic [SW-1:0]                 i_side,
    output twp_pkg::t_ctl                 o_ctl,
    output logic [1:0][CB:0]              o_k,
    output logic [1:0][2*CB+1:0]          o_q,
    output logic [1:0][2*CB-1:0]          o_lim,
    output logic [SW-1:0]                 o_side
);

    localparam int unsigned KW = CB + 1;
    localparam int unsigned QW = 2 * KW;

    logic [1:0][QW-1:0] n_cand;
    logic [1:0][KW-1:0] n_k;
    logic [1:0][QW-1:0] n_q;

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            n_cand[l] = i_q[l] + (QW'(i_k[l]) << (BIT + 1))
                      + (QW'(1) << (2 * BIT)) - (QW'(1) << BIT);
            if (n_cand[l] <= QW'(i_lim[l])) begin
                n_k[l] = i_k[l] | (KW'(1) << BIT);
                n_q[l] = n_cand[l];
            end else begin
                n_k[l] = i_k[l];
                n_q[l] = i_q[l];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ctl <= '0;
        end else begin
            o_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        o_k    <= n_k;
        o_q    <= n_q;
        o_lim  <= i_lim;
        o_side <= i_side;
    end

endmodule

// File: rtl/triangular_work_partition.sv
// ----------------------------------------------------------------------------
// triangular_work_partition
// Gives the row range [begin,end) of one worker, block or pair balanced.
// ----------------------------------------------------------------------------
// Use:
//   Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx
//   (0 item count, 1 worker count, 2 split mode) at the clock edge; write
//   only while no request is in flight.
//   Request: worker rank on i_worker_rank, taken at an edge with start high
//   and busy low. busy stays low, so a request can be taken every cycle.
//   Result: o_range_begin, o_range_end and o_rank_ok are shown for one cycle
//   with o_strobe high, one result per request, in request order.
//   Throughput is one request per cycle; the pipeline runs through a chain of
//   2*COUNT_BITS division cells and COUNT_BITS+1 root cells.
//   Reset (synchronous, low) empties the chain and loads item count 1,
//   worker count 1, triangular mode. The receiver cannot stall; each
//   result must be taken in its strobe cycle.
// ----------------------------------------------------------------------------
module triangular_work_partition #(
    parameter int unsigned COUNT_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [twp_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [twp_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                             start,
    output logic                             busy,
    input  logic [15:0]                      i_worker_rank,
    output logic                             o_strobe,
    output logic [15:0]                      o_range_begin,
    output logic [15:0]                      o_range_end,
    output logic                             o_rank_ok
);

    localparam int unsigned CB  = COUNT_BITS;
    localparam int unsigned DW  = 2 * CB;
    localparam int unsigned KW  = CB + 1;
    localparam int unsigned RN  = CB + 1;
    localparam int unsigned DSW = 2 * CB;
    localparam int unsigned RSW = CB + 2 * DW;
    localparam int unsigned LAT = 3 * CB + 6;
    localparam logic [63:0] PAIR_LIMIT = 64'd2147483647;

    // configuration
    logic [CB-1:0] r_item_count;
    logic [CB-1:0] r_worker_count;
    logic          r_split_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_count   <= CB'(1);
            r_worker_count <= CB'(1);
            r_split_mode   <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (twp_pkg::t_cfg_idx'(i_cfg_idx))
                twp_pkg::REG_ITEM_COUNT:   r_item_count   <= i_cfg_data[CB-1:0];
                twp_pkg::REG_WORKER_COUNT: r_worker_count <= i_cfg_data[CB-1:0];
                twp_pkg::REG_SPLIT_MODE:   r_split_mode   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    // input stage
    twp_pkg::t_ctl r_a_ctl;
    logic [CB-1:0] r_a_rank;
    logic [CB-1:0] r_a_n;
    logic [CB-1:0] r_a_size;
    logic [CB-1:0] n_a_rank;
    twp_pkg::t_ctl n_a_ctl;

    always_comb begin
        n_a_rank      = i_worker_rank[CB-1:0];
        n_a_ctl.vld   = start & ~busy;
        n_a_ctl.ok    = (n_a_rank < r_worker_count);
        n_a_ctl.nz    = (r_item_count != '0);
        n_a_ctl.blk   = ~r_split_mode;
        n_a_ctl.first = (n_a_rank == '0);
        n_a_ctl.last  = (n_a_rank == r_worker_count - CB'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_ctl <= '0;
        end else begin
            r_a_ctl <= n_a_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_rank <= n_a_rank;
        r_a_n    <= r_item_count;
        r_a_size <= r_worker_count;
    end

    // n(n-1) stage
    twp_pkg::t_ctl r_p_ctl;
    logic [DW-1:0] r_p_prod;
    logic [CB-1:0] r_p_rank;
    logic [CB-1:0] r_p_n;
    logic [CB-1:0] r_p_size;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_ctl <= '0;
        end else begin
            r_p_ctl <= r_a_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p_prod <= DW'(r_a_n * (r_a_n - CB'(1)));
        r_p_rank <= r_a_rank;
        r_p_n    <= r_a_n;
        r_p_size <= r_a_size;
    end

    // division chain: rows or pairs by worker count
    twp_pkg::t_ctl d_ctl  [DW+1];
    logic [CB-1:0] d_rem  [DW+1];
    logic [DW-1:0] d_dq   [DW+1];
    logic [CB-1:0] d_div  [DW+1];
    logic [DSW-1:0] d_side [DW+1];
    logic          n_p_blk;

    always_comb begin
        n_p_blk = r_p_ctl.blk | ((64'(r_p_prod) + 64'(r_p_n)) > PAIR_LIMIT);
        d_ctl[0]     = r_p_ctl;
        d_ctl[0].blk = n_p_blk;
        d_rem[0]     = '0;
        d_dq[0]      = n_p_blk ? DW'(r_p_n) : (r_p_prod >> 1);
        d_div[0]     = r_p_size;
        d_side[0]    = {r_p_rank, r_p_n};
    end

    for (genvar g = 0; g < DW; g++) begin : g_div
        twp_div_cell #(.CB(CB), .DW(DW), .SW(DSW)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_ctl  (d_ctl[g]),
            .i_rem  (d_rem[g]),
            .i_dq   (d_dq[g]),
            .i_div  (d_div[g]),
            .i_side (d_side[g]),
            .o_ctl  (d_ctl[g+1]),
            .o_rem  (d_rem[g+1]),
            .o_dq   (d_dq[g+1]),
            .o_div  (d_div[g+1]),
            .o_side (d_side[g+1])
        );
    end

    // offset product stage
    logic [CB-1:0] m_rank;
    logic [CB-1:0] m_n;
    logic [CB-1:0] m_op;
    logic [CB-1:0] m_min;
    twp_pkg::t_ctl r_m_ctl;
    logic [DW-1:0] r_m_base;
    logic [CB-1:0] r_m_add;
    logic          r_m_lt;
    logic [DW-1:0] r_m_per;
    logic [CB-1:0] r_m_n;

    always_comb begin
        {m_rank, m_n} = d_side[DW];
        m_op  = d_ctl[DW].blk ? m_rank : (d_div[DW] - CB'(1) - m_rank);
        m_min = (m_rank < d_rem[DW]) ? m_rank : d_rem[DW];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_ctl <= '0;
        end else begin
            r_m_ctl <= d_ctl[DW];
        end
    end

    always_ff @(posedge i_clk) begin
        r_m_base <= DW'(m_op * d_dq[DW]);
        r_m_add  <= d_ctl[DW].blk ? m_min : '0;
        r_m_lt   <= d_ctl[DW].blk & (m_rank < d_rem[DW]);
        r_m_per  <= d_dq[DW];
        r_m_n    <= m_n;
    end

    // bound sum stage
    logic [DW-1:0] n_f_s;
    twp_pkg::t_ctl r_f_ctl;
    logic [DW-1:0] r_f_s;
    logic [DW-1:0] r_f_f;
    logic [CB-1:0] r_f_n;

    always_comb begin
        n_f_s = r_m_base + DW'(r_m_add);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_ctl <= '0;
        end else begin
            r_f_ctl <= r_m_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_f_s <= n_f_s;
        r_f_f <= n_f_s + r_m_per + DW'(r_m_lt);
        r_f_n <= r_m_n;
    end

    // root chain, lane 0 on the start offset, lane 1 on the end offset
    twp_pkg::t_ctl          q_ctl  [RN+1];
    logic [1:0][KW-1:0]     q_k    [RN+1];
    logic [1:0][2*KW-1:0]   q_q    [RN+1];
    logic [1:0][DW-1:0]     q_lim  [RN+1];
    logic [RSW-1:0]         q_side [RN+1];

    always_comb begin
        q_ctl[0]    = r_f_ctl;
        q_k[0]      = '0;
        q_q[0]      = '0;
        q_lim[0][0] = {r_f_s[DW-2:0], 1'b0};
        q_lim[0][1] = {r_f_f[DW-2:0], 1'b0};
        q_side[0]   = {r_f_n, r_f_s, r_f_f};
    end

    for (genvar g = 0; g < RN; g++) begin : g_root
        twp_root_cell #(.CB(CB), .BIT(CB - g), .SW(RSW)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_ctl  (q_ctl[g]),
            .i_k    (q_k[g]),
            .i_q    (q_q[g]),
            .i_lim  (q_lim[g]),
            .i_side (q_side[g]),
            .o_ctl  (q_ctl[g+1]),
            .o_k    (q_k[g+1]),
            .o_q    (q_q[g+1]),
            .o_lim  (q_lim[g+1]),
            .o_side (q_side[g+1])
        );
    end

    // result stage
    twp_pkg::t_ctl o_c;
    logic [CB-1:0] o_n;
    logic [DW-1:0] o_s;
    logic [DW-1:0] o_f;
    logic [KW-1:0] o_dbeg;
    logic [KW-1:0] o_dend;
    logic [CB-1:0] n_beg;
    logic [CB-1:0] n_end;
    logic          r_strobe;
    logic [15:0]   r_begin;
    logic [15:0]   r_end;
    logic          r_ok;

    always_comb begin
        o_c = q_ctl[RN];
        {o_n, o_s, o_f} = q_side[RN];
        o_dbeg = {1'b0, o_n} - q_k[RN][1];
        o_dend = {1'b0, o_n} - q_k[RN][0];
        if (!(o_c.ok && o_c.nz)) begin
            n_beg = '0;
            n_end = '0;
        end else if (o_c.blk) begin
            n_beg = o_s[CB-1:0];
            n_end = (o_f > DW'(o_n) || o_c.last) ? o_n : o_f[CB-1:0];
        end else begin
            n_beg = o_c.first ? '0 : o_dbeg[CB-1:0];
            n_end = o_c.last ? o_n : o_dend[CB-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= o_c.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_begin <= 16'(n_beg);
        r_end   <= 16'(n_end);
        r_ok    <= o_c.ok;
    end

    assign o_strobe      = r_strobe;
    assign o_range_begin = r_begin;
    assign o_range_end   = r_end;
    assign o_rank_ok     = r_ok;

`ifndef ASSERT_OFF
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_strobe)
        else $error("request produced no result at the fixed latency");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start, LAT))
        else $error("result without a matching request");

    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_rank_ok) |-> (o_range_begin <= o_range_end))
        else $error("range begin above range end");

    a_bad_rank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_rank_ok) |-> (o_range_begin == '0 && o_range_end == '0))
        else $error("flagged rank returned a non-empty range");
`endif

endmodule
